/* src/bmh_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_pkg: shared constants of the binary min-heap
// Operation and status codes, field widths and the default capacity.
// ----------------------------------------------------------------------------
package bmh_pkg;

    // Default number of heap entries
    localparam int CAPACITY_DEF = 64;

    // Field widths fixed by the interface
    localparam int VAL_W     = 32;
    localparam int OP_W      = 2;
    localparam int STATUS_W  = 2;
    localparam int EIDX_W    = 6;
    localparam int ECNT_W    = 7;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
    localparam logic [OP_W-1:0] OP_DUMP   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

/* src/binary_min_heap_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_min_heap_top: array-backed binary min-heap of signed 32-bit values
// Insert with sift-up, load with bottom-up build, and dump in index order.
// ----------------------------------------------------------------------------
// The heap lives in one RAM with a single read port whose read data is
// registered, and one request is worked on at a time. An insert is accepted,
// then sifts up with a parent read and a compare per level, and ends with a
// result. A load that is not marked last writes its element and gives a
// result. A load marked last adds the build, which visits nodes count/2-1 down
// to 0: it fetches each node, then per level reads the left child and, if
// present, the right child for a compare, one compare per level that the
// element sinks plus the one where it stops, or it writes the element back
// where it comes to rest on a leaf. A dump is accepted and then reads and
// outputs each element in turn, and an output stall holds it. The result of a
// request sits in an output register, so a new request is taken while it
// waits. Operation code 3 is accepted and has no effect.
// ----------------------------------------------------------------------------
module binary_min_heap_top
    import bmh_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // request channel
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [OP_W-1:0]            operation,
    input  logic signed [VAL_W-1:0]    value,
    input  logic                       last_of_load,
    // result channel
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [STATUS_W-1:0]        status,
    output logic signed [VAL_W-1:0]    element_value,
    output logic [EIDX_W-1:0]          element_index,
    output logic [ECNT_W-1:0]          element_count,
    output logic                       last_of_run
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CH_W  = IDX_W + 2;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [10:0]
    {
        S_IDLE     = 11'b00000000001,
        S_UP_RD    = 11'b00000000010,
        S_UP_CMP   = 11'b00000000100,
        S_DN_RDX   = 11'b00000001000,
        S_DN_X     = 11'b00000010000,
        S_DN_RDL   = 11'b00000100000,
        S_DN_L     = 11'b00001000000,
        S_DN_R     = 11'b00010000000,
        S_DUMP_RD  = 11'b00100000000,
        S_DUMP_OUT = 11'b01000000000,
        S_RES      = 11'b10000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      lip_reg, lip_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [IDX_W-1:0]          node_reg, node_next;
    logic signed [VAL_W-1:0]   x_reg, x_next;
    logic signed [VAL_W-1:0]   lv_reg, lv_next;
    logic signed [VAL_W-1:0]   root_reg;
    logic [STATUS_W-1:0]       st_reg, st_next;

    logic                      out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic signed [VAL_W-1:0]   evalue_reg, evalue_next;
    logic [EIDX_W-1:0]         eidx_reg, eidx_next;
    logic [ECNT_W-1:0]         ecnt_reg, ecnt_next;
    logic                      elast_reg, elast_next;

    // RAM ports
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    logic [VAL_W-1:0]          ram_wdata;
    logic                      ram_re;
    logic [IDX_W-1:0]          ram_raddr;
    logic [VAL_W-1:0]          ram_rdata;
    logic signed [VAL_W-1:0]   rd_val;

    // Tree neighbors of the current position
    logic [CH_W-1:0]           lchild, rchild, cnt_ext;
    logic [IDX_W-1:0]          parent;
    logic                      slot_free;
    logic                      in_acc;

    bmh_ram #(
        .WIDTH (VAL_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_val    = $signed(ram_rdata);
    assign lchild    = {1'b0, idx_reg, 1'b1};
    assign rchild    = lchild + CH_W'(1);
    assign cnt_ext   = CH_W'(cnt_reg);
    assign parent    = IDX_W'((idx_reg - IDX_W'(1)) >> 1);
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_acc    = in_valid && !in_stall;

    // Control and datapath next state
    always_comb
    begin
        logic [CNT_W-1:0] cnt0;
        logic [CNT_W-1:0] cnt_new;
        logic [CNT_W-1:0] half;
        logic             lsm;
        logic signed [VAL_W-1:0] cand;

        state_next     = state_reg;
        cnt_next       = cnt_reg;
        lip_next       = lip_reg;
        idx_next       = idx_reg;
        node_next      = node_reg;
        x_next         = x_reg;
        lv_next        = lv_reg;
        st_next        = st_reg;
        out_valid_next = out_valid_reg && out_stall;
        status_next    = status_reg;
        evalue_next    = evalue_reg;
        eidx_next      = eidx_reg;
        ecnt_next      = ecnt_reg;
        elast_next     = elast_reg;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = '0;
        cnt0           = lip_reg ? cnt_reg : '0;
        cnt_new        = cnt0;
        half           = '0;
        lsm            = lv_reg < x_reg;
        cand           = lsm ? lv_reg : x_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    case (operation)
                        OP_INSERT:
                        begin
                            lip_next = 1'b0;
                            if (cnt_reg >= CAP_CNT)
                            begin
                                st_next    = ST_FULL;
                                state_next = S_RES;
                            end
                            else
                            begin
                                st_next    = ST_OK;
                                x_next     = value;
                                idx_next   = cnt_reg[IDX_W-1:0];
                                cnt_next   = cnt_reg + CNT_W'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        OP_LOAD:
                        begin
                            // first load of a run empties the heap
                            lip_next = !last_of_load;
                            if (cnt0 >= CAP_CNT)
                            begin
                                st_next = ST_FULL;
                            end
                            else
                            begin
                                st_next   = ST_OK;
                                ram_we    = 1'b1;
                                ram_waddr = cnt0[IDX_W-1:0];
                                ram_wdata = value;
                                cnt_new   = cnt0 + CNT_W'(1);
                            end
                            cnt_next   = cnt_new;
                            half       = cnt_new >> 1;
                            state_next = S_RES;
                            if (last_of_load && (half != '0))
                            begin
                                node_next  = IDX_W'(half - CNT_W'(1));
                                state_next = S_DN_RDX;
                            end
                        end
                        OP_DUMP:
                        begin
                            lip_next = 1'b0;
                            if (cnt_reg == '0)
                            begin
                                st_next    = ST_EMPTY;
                                state_next = S_RES;
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_DUMP_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            // Sift-up: read the parent, or settle at the root
            S_UP_RD:
            begin
                if (idx_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = idx_reg;
                    ram_wdata  = x_reg;
                    state_next = S_RES;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = parent;
                    state_next = S_UP_CMP;
                end
            end

            // Move the parent down while it is strictly greater
            S_UP_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if (x_reg < rd_val)
                begin
                    ram_wdata  = rd_val;
                    idx_next   = parent;
                    state_next = S_UP_RD;
                end
                else
                begin
                    ram_wdata  = x_reg;
                    state_next = S_RES;
                end
            end

            // Build: fetch the element at the next node
            S_DN_RDX:
            begin
                ram_re     = 1'b1;
                ram_raddr  = node_reg;
                state_next = S_DN_X;
            end

            S_DN_X:
            begin
                x_next     = rd_val;
                idx_next   = node_reg;
                state_next = S_DN_RDL;
            end

            // Sift-down: read the left child or settle at a leaf
            S_DN_RDL:
            begin
                if (lchild < cnt_ext)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = lchild[IDX_W-1:0];
                    state_next = S_DN_L;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    ram_wdata = x_reg;
                    if (node_reg == '0)
                    begin
                        state_next = S_RES;
                    end
                    else
                    begin
                        node_next  = node_reg - IDX_W'(1);
                        state_next = S_DN_RDX;
                    end
                end
            end

            // Left child in hand; fetch the right one if present
            S_DN_L:
            begin
                if (rchild < cnt_ext)
                begin
                    lv_next    = rd_val;
                    ram_re     = 1'b1;
                    ram_raddr  = rchild[IDX_W-1:0];
                    state_next = S_DN_R;
                end
                else
                begin
                    ram_we    = 1'b1;
                    ram_waddr = idx_reg;
                    if (rd_val < x_reg)
                    begin
                        ram_wdata  = rd_val;
                        idx_next   = lchild[IDX_W-1:0];
                        state_next = S_DN_RDL;
                    end
                    else
                    begin
                        ram_wdata = x_reg;
                        if (node_reg == '0)
                        begin
                            state_next = S_RES;
                        end
                        else
                        begin
                            node_next  = node_reg - IDX_W'(1);
                            state_next = S_DN_RDX;
                        end
                    end
                end
            end

            // Both children: strict compares, left wins a tie
            S_DN_R:
            begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg;
                if (rd_val < cand)
                begin
                    ram_wdata  = rd_val;
                    idx_next   = rchild[IDX_W-1:0];
                    state_next = S_DN_RDL;
                end
                else if (lsm)
                begin
                    ram_wdata  = lv_reg;
                    idx_next   = lchild[IDX_W-1:0];
                    state_next = S_DN_RDL;
                end
                else
                begin
                    ram_wdata = x_reg;
                    if (node_reg == '0)
                    begin
                        state_next = S_RES;
                    end
                    else
                    begin
                        node_next  = node_reg - IDX_W'(1);
                        state_next = S_DN_RDX;
                    end
                end
            end

            // Dump: one element per read
            S_DUMP_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_OK;
                    evalue_next    = rd_val;
                    eidx_next      = EIDX_W'(idx_reg);
                    ecnt_next      = ECNT_W'(cnt_reg);
                    elast_next     = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
                    if (elast_next)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_DUMP_RD;
                    end
                end
            end

            // Single result of insert, load or empty dump
            S_RES:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    evalue_next    = (cnt_reg != '0) ? root_reg : '0;
                    eidx_next      = '0;
                    ecnt_next      = ECNT_W'(cnt_reg);
                    elast_next     = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            lip_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            lip_reg       <= lip_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        node_reg   <= node_next;
        x_reg      <= x_next;
        lv_reg     <= lv_next;
        st_reg     <= st_next;
        status_reg <= status_next;
        evalue_reg <= evalue_next;
        eidx_reg   <= eidx_next;
        ecnt_reg   <= ecnt_next;
        elast_reg  <= elast_next;
    end

    // Shadow of entry 0 for the root report
    always_ff @(posedge clk)
    begin
        if (ram_we && (ram_waddr == '0))
        begin
            root_reg <= $signed(ram_wdata);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign element_value = evalue_reg;
    assign element_index = eidx_reg;
    assign element_count = ecnt_reg;
    assign last_of_run   = elast_reg;

`ifndef NO_ASSERTIONS
    // Count never exceeds the capacity
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CAP_CNT)
        else $error("element count above capacity");

    // An insert into a heap with room grows it by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && (operation == OP_INSERT) && (cnt_reg < CAP_CNT))
        |=> (cnt_reg == $past(cnt_reg) + CNT_W'(1)))
        else $error("insert did not grow the heap");

    // Empty-dump result reports no elements
    a_empty_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_EMPTY))
        |-> ((ecnt_reg == '0) && elast_reg))
        else $error("empty dump result malformed");

    // Inside a dump run, the index stays below the count
    a_dump_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_OK) && !elast_reg)
        |-> ((ECNT_W'(eidx_reg) + ECNT_W'(1)) < ecnt_reg))
        else $error("dump index out of range");
`endif

endmodule

/* src/bmh_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmh_ram: simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module bmh_ram
    import bmh_pkg::*;
#(
    parameter int WIDTH = VAL_W,
    parameter int DEPTH = CAPACITY_DEF
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
